// ===== design/arithmetic_token_lexer_top_defines.svh =====
// ============================================================================
// Assertion macros for the arithmetic token lexer
// Concurrent checks that become empty when SYNTH is defined.
// ============================================================================
`ifndef ARITHMETIC_TOKEN_LEXER_TOP_DEFINES_SVH
`define ARITHMETIC_TOKEN_LEXER_TOP_DEFINES_SVH

`ifndef SYNTH
`define ATL_ASSERT_HOLDS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("lexer check failed");
`define ATL_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("lexer check failed");
`else
`define ATL_ASSERT_HOLDS(label, clk, rst_n, expr)
`define ATL_ASSERT_NEXT(label, clk, rst_n, cond, expr)
`endif

`endif

// ===== design/atl_pkg.sv =====
// ============================================================================
// Arithmetic token lexer package
// Shared constants, character codes, token types and helper functions.
// ============================================================================
package atl_pkg;

    localparam int MAX_TOKEN_LENGTH = 255;
    localparam int LEN_W            = $clog2(MAX_TOKEN_LENGTH + 1);
    localparam int OUT_LEN_W        = 8;
    localparam int OUT_LEN_MAX      = 255;
    localparam int CHAR_W           = 8;
    localparam int KIND_W           = 4;
    localparam int FIFO_DEPTH       = 4;
    localparam int FIFO_PTR_W       = $clog2(FIFO_DEPTH);
    localparam int FIFO_LVL_W       = $clog2(FIFO_DEPTH + 1);

    localparam logic [CHAR_W-1:0] CH_DOT        = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_UPPER_E    = 8'h45;
    localparam logic [CHAR_W-1:0] CH_LOWER_E    = 8'h65;
    localparam logic [CHAR_W-1:0] CH_MINUS      = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [CHAR_W-1:0] CH_SLASH      = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_PLUS       = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_STAR       = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_EQUAL      = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_CARET      = 8'h5E;
    localparam logic [CHAR_W-1:0] CH_LPAREN     = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN     = 8'h29;
    localparam logic [CHAR_W-1:0] CH_ZERO       = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE       = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UPPER_A    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z    = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LOWER_A    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z    = 8'h7A;

    typedef enum logic {
        OP_CHAR = 1'b0,
        OP_EOL  = 1'b1
    } op_t;

    typedef enum logic [8:0] {
        MODE_IDLE    = 9'b000000001,
        MODE_MINUS   = 9'b000000010,
        MODE_SLASH   = 9'b000000100,
        MODE_COMMENT = 9'b000001000,
        MODE_INT     = 9'b000010000,
        MODE_FRAC    = 9'b000100000,
        MODE_EXPS    = 9'b001000000,
        MODE_EXPD    = 9'b010000000,
        MODE_IDENT   = 9'b100000000
    } mode_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_INT     = 4'd0,
        KIND_REAL    = 4'd1,
        KIND_IDENT   = 4'd2,
        KIND_COMMENT = 4'd3,
        KIND_DIV     = 4'd4,
        KIND_ADD     = 4'd5,
        KIND_SUB     = 4'd6,
        KIND_MUL     = 4'd7,
        KIND_ASSIGN  = 4'd8,
        KIND_POW     = 4'd9,
        KIND_LPAREN  = 4'd10,
        KIND_RPAREN  = 4'd11,
        KIND_IDERR   = 4'd12
    } kind_t;

    typedef struct packed {
        kind_t                 kind;
        logic [OUT_LEN_W-1:0]  length;
        logic                  last;
    } token_t;

    typedef struct packed {
        logic [1:0] count;
        token_t     tok0;
        token_t     tok1;
    } lex_out_t;

    typedef struct packed {
        logic [FIFO_LVL_W-1:0] level;
        logic                  room_two;
        logic                  empty;
    } fifo_status_t;

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return c inside {[CH_ZERO:CH_NINE]};
    endfunction

    function automatic logic is_alpha(input logic [CHAR_W-1:0] c);
        return c inside {[CH_UPPER_A:CH_UPPER_Z], [CH_LOWER_A:CH_LOWER_Z]};
    endfunction

    function automatic logic [LEN_W-1:0] bump_len(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] res;
        if (32'(len) < MAX_TOKEN_LENGTH)
        begin
            res = len + LEN_W'(1);
        end
        else
        begin
            res = LEN_W'(MAX_TOKEN_LENGTH);
        end
        return res;
    endfunction

    function automatic logic [OUT_LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
        logic [31:0] wide;
        wide = 32'(len);
        if (wide > 32'(OUT_LEN_MAX))
        begin
            wide = 32'(OUT_LEN_MAX);
        end
        return wide[OUT_LEN_W-1:0];
    endfunction

endpackage

// ===== design/atl_lex_step.sv =====
// ============================================================================
// Lexer step
// Holds the scan mode and token length and works out the tokens of one beat.
// ============================================================================
module atl_lex_step (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  atl_pkg::op_t                  op,
    input  logic [atl_pkg::CHAR_W-1:0]    character,
    output atl_pkg::lex_out_t             lex_out
);

    atl_pkg::mode_t                  mode_reg;
    atl_pkg::mode_t                  mode_next;
    logic [atl_pkg::LEN_W-1:0]       len_reg;
    logic [atl_pkg::LEN_W-1:0]       len_next;

    logic                            a_vld;
    atl_pkg::kind_t                  a_kind;
    logic                            rescan;
    logic                            b_vld;
    atl_pkg::kind_t                  b_kind;
    atl_pkg::mode_t                  st_mode;
    logic [atl_pkg::LEN_W-1:0]       st_len;
    atl_pkg::token_t                 tok_a;
    atl_pkg::token_t                 tok_b;
    logic                            dig;
    logic                            alp;
    logic [atl_pkg::LEN_W-1:0]       len_inc;

    assign dig     = atl_pkg::is_digit(character);
    assign alp     = atl_pkg::is_alpha(character);
    assign len_inc = atl_pkg::bump_len(len_reg);

    // Scan from the idle state.
    always_comb
    begin
        st_mode = atl_pkg::MODE_IDLE;
        st_len  = '0;
        b_vld   = 1'b0;
        b_kind  = atl_pkg::KIND_ADD;
        if (dig)
        begin
            st_mode = atl_pkg::MODE_INT;
            st_len  = atl_pkg::LEN_W'(1);
        end
        else if (character == atl_pkg::CH_MINUS)
        begin
            st_mode = atl_pkg::MODE_MINUS;
            st_len  = atl_pkg::LEN_W'(1);
        end
        else if (character == atl_pkg::CH_SLASH)
        begin
            st_mode = atl_pkg::MODE_SLASH;
            st_len  = atl_pkg::LEN_W'(1);
        end
        else if (alp)
        begin
            st_mode = atl_pkg::MODE_IDENT;
            st_len  = atl_pkg::LEN_W'(1);
        end
        else if (character == atl_pkg::CH_LPAREN)
        begin
            b_vld  = 1'b1;
            b_kind = atl_pkg::KIND_LPAREN;
        end
        else if (character == atl_pkg::CH_RPAREN)
        begin
            b_vld  = 1'b1;
            b_kind = atl_pkg::KIND_RPAREN;
        end
        else if (character == atl_pkg::CH_PLUS)
        begin
            b_vld  = 1'b1;
            b_kind = atl_pkg::KIND_ADD;
        end
        else if (character == atl_pkg::CH_STAR)
        begin
            b_vld  = 1'b1;
            b_kind = atl_pkg::KIND_MUL;
        end
        else if (character == atl_pkg::CH_EQUAL)
        begin
            b_vld  = 1'b1;
            b_kind = atl_pkg::KIND_ASSIGN;
        end
        else if (character == atl_pkg::CH_CARET)
        begin
            b_vld  = 1'b1;
            b_kind = atl_pkg::KIND_POW;
        end
    end

    // Offer the beat to the pending token.
    always_comb
    begin
        a_vld     = 1'b0;
        a_kind    = atl_pkg::KIND_INT;
        rescan    = 1'b1;
        mode_next = mode_reg;
        len_next  = len_inc;
        if (op == atl_pkg::OP_EOL)
        begin
            rescan    = 1'b0;
            mode_next = atl_pkg::MODE_IDLE;
            len_next  = '0;
            a_vld     = (mode_reg != atl_pkg::MODE_IDLE);
            case (mode_reg)
                atl_pkg::MODE_MINUS:   a_kind = atl_pkg::KIND_SUB;
                atl_pkg::MODE_SLASH:   a_kind = atl_pkg::KIND_DIV;
                atl_pkg::MODE_COMMENT: a_kind = atl_pkg::KIND_COMMENT;
                atl_pkg::MODE_INT:     a_kind = atl_pkg::KIND_INT;
                atl_pkg::MODE_IDENT:   a_kind = atl_pkg::KIND_IDENT;
                default:               a_kind = atl_pkg::KIND_REAL;
            endcase
        end
        else
        begin
            case (mode_reg)
                atl_pkg::MODE_MINUS:
                begin
                    if (dig)
                    begin
                        rescan    = 1'b0;
                        mode_next = atl_pkg::MODE_INT;
                    end
                    else
                    begin
                        a_vld  = 1'b1;
                        a_kind = atl_pkg::KIND_SUB;
                    end
                end
                atl_pkg::MODE_SLASH:
                begin
                    if (character == atl_pkg::CH_SLASH)
                    begin
                        rescan    = 1'b0;
                        mode_next = atl_pkg::MODE_COMMENT;
                    end
                    else
                    begin
                        a_vld  = 1'b1;
                        a_kind = atl_pkg::KIND_DIV;
                    end
                end
                atl_pkg::MODE_COMMENT:
                begin
                    rescan = 1'b0;
                end
                atl_pkg::MODE_INT:
                begin
                    if (dig)
                    begin
                        rescan = 1'b0;
                    end
                    else if (character == atl_pkg::CH_DOT)
                    begin
                        rescan    = 1'b0;
                        mode_next = atl_pkg::MODE_FRAC;
                    end
                    else if (!alp)
                    begin
                        a_vld  = 1'b1;
                        a_kind = atl_pkg::KIND_INT;
                    end
                end
                atl_pkg::MODE_FRAC:
                begin
                    if (dig)
                    begin
                        rescan = 1'b0;
                    end
                    else if (character == atl_pkg::CH_LOWER_E ||
                             character == atl_pkg::CH_UPPER_E)
                    begin
                        rescan    = 1'b0;
                        mode_next = atl_pkg::MODE_EXPS;
                    end
                    else if (character != atl_pkg::CH_DOT)
                    begin
                        a_vld  = 1'b1;
                        a_kind = atl_pkg::KIND_REAL;
                    end
                end
                atl_pkg::MODE_EXPS, atl_pkg::MODE_EXPD:
                begin
                    if (dig || (mode_reg == atl_pkg::MODE_EXPS &&
                                character == atl_pkg::CH_MINUS))
                    begin
                        rescan    = 1'b0;
                        mode_next = atl_pkg::MODE_EXPD;
                    end
                    else if (!(character == atl_pkg::CH_DOT ||
                               character == atl_pkg::CH_UNDERSCORE || alp))
                    begin
                        a_vld  = 1'b1;
                        a_kind = atl_pkg::KIND_REAL;
                    end
                end
                atl_pkg::MODE_IDENT:
                begin
                    if (alp || dig || character == atl_pkg::CH_UNDERSCORE)
                    begin
                        rescan = 1'b0;
                    end
                    else
                    begin
                        a_vld  = 1'b1;
                        a_kind = (character == atl_pkg::CH_DOT) ?
                                 atl_pkg::KIND_IDERR : atl_pkg::KIND_IDENT;
                    end
                end
                default:
                begin
                    rescan = 1'b1;
                end
            endcase
            if (rescan)
            begin
                mode_next = st_mode;
                len_next  = st_len;
            end
        end
    end

    always_comb
    begin
        tok_a.kind   = a_kind;
        tok_a.length = atl_pkg::clamp_len(len_reg);
        tok_a.last   = 1'b0;
        tok_b.kind   = b_kind;
        tok_b.length = atl_pkg::OUT_LEN_W'(1);
        tok_b.last   = 1'b1;
        lex_out.tok0 = tok_a;
        lex_out.tok1 = tok_b;
        lex_out.count = 2'd0;
        if (a_vld && rescan && b_vld)
        begin
            lex_out.count = 2'd2;
        end
        else if (a_vld)
        begin
            lex_out.count     = 2'd1;
            lex_out.tok0.last = 1'b1;
        end
        else if (rescan && b_vld)
        begin
            lex_out.count = 2'd1;
            lex_out.tok0  = tok_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= atl_pkg::MODE_IDLE;
            len_reg  <= '0;
        end
        else if (advance)
        begin
            mode_reg <= mode_next;
            len_reg  <= len_next;
        end
    end

endmodule

// ===== design/atl_tok_fifo.sv =====
// ============================================================================
// Token queue
// Small register queue that takes up to two tokens per cycle and gives one.
// ============================================================================
module atl_tok_fifo (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [1:0]              push_cnt,
    input  atl_pkg::token_t         tok0,
    input  atl_pkg::token_t         tok1,
    input  logic                    pop,
    output atl_pkg::token_t         head,
    output atl_pkg::fifo_status_t   status
);

    atl_pkg::token_t                     mem_reg [atl_pkg::FIFO_DEPTH];
    logic [atl_pkg::FIFO_PTR_W-1:0]      wr_ptr_reg;
    logic [atl_pkg::FIFO_PTR_W-1:0]      wr_ptr_next;
    logic [atl_pkg::FIFO_PTR_W-1:0]      wr_ptr_plus1;
    logic [atl_pkg::FIFO_PTR_W-1:0]      rd_ptr_reg;
    logic [atl_pkg::FIFO_PTR_W-1:0]      rd_ptr_next;
    logic [atl_pkg::FIFO_LVL_W-1:0]      level_reg;
    logic [atl_pkg::FIFO_LVL_W-1:0]      level_next;

    assign wr_ptr_plus1 = wr_ptr_reg + atl_pkg::FIFO_PTR_W'(1);
    assign wr_ptr_next  = wr_ptr_reg + atl_pkg::FIFO_PTR_W'(push_cnt);
    assign rd_ptr_next  = rd_ptr_reg + atl_pkg::FIFO_PTR_W'(pop);
    assign level_next   = level_reg + atl_pkg::FIFO_LVL_W'(push_cnt)
                          - atl_pkg::FIFO_LVL_W'(pop);

    assign head            = mem_reg[rd_ptr_reg];
    assign status.level    = level_reg;
    assign status.empty    = (level_reg == '0);
    assign status.room_two = (32'(level_reg) <= atl_pkg::FIFO_DEPTH - 2);

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < atl_pkg::FIFO_DEPTH; i++)
        begin
            if (push_cnt != 2'd0 && wr_ptr_reg == atl_pkg::FIFO_PTR_W'(i))
            begin
                mem_reg[i] <= tok0;
            end
            else if (push_cnt == 2'd2 && wr_ptr_plus1 == atl_pkg::FIFO_PTR_W'(i))
            begin
                mem_reg[i] <= tok1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

endmodule

// ===== design/arithmetic_token_lexer_top.sv =====
// ============================================================================
// Arithmetic token lexer
// Splits a stream of line characters into tokens reported as kind and length.
// ============================================================================
//  Channel | Dir | tdata                         | tuser / tlast
//  s_*     | in  | [7:0] character               | tuser: op (1 = end of line)
//  m_*     | out | [7:0] length                  | tuser: [3:0] kind; tlast: last token
//
//  An input beat is registered, scanned in the next cycle and its zero, one
//  or two tokens enter a four-entry token queue; one beat per clock is taken
//  while the queue has room for two tokens. Otherwise a beat waits in the input
//  register, so output stalls back up to s_tready.
//  Reset clears the scan state to idle with length zero and empties the queue.
// ============================================================================
`include "arithmetic_token_lexer_top_defines.svh"

module arithmetic_token_lexer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] character
    input  logic        s_tuser,   // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] length
    output logic [3:0]  m_tuser,   // [3:0] kind
    output logic        m_tlast
);

    logic                              in_vld_reg;
    logic                              in_vld_next;
    atl_pkg::op_t                      op_reg;
    logic [atl_pkg::CHAR_W-1:0]        char_reg;
    logic                              s_fire;
    logic                              consume;
    logic [1:0]                        push_cnt;
    atl_pkg::lex_out_t                 lex_out;
    atl_pkg::token_t                   head;
    atl_pkg::fifo_status_t             fifo_stat;

    assign consume   = in_vld_reg && fifo_stat.room_two;
    assign s_tready  = !in_vld_reg || consume;
    assign s_fire    = s_tvalid && s_tready;
    assign push_cnt  = consume ? lex_out.count : 2'd0;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (s_fire)
        begin
            in_vld_next = 1'b1;
        end
        else if (consume)
        begin
            in_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            op_reg   <= atl_pkg::op_t'(s_tuser);
            char_reg <= s_tdata;
        end
    end

    atl_lex_step u_lex_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (consume),
        .op        (op_reg),
        .character (char_reg),
        .lex_out   (lex_out)
    );

    atl_tok_fifo u_tok_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_cnt (push_cnt),
        .tok0     (lex_out.tok0),
        .tok1     (lex_out.tok1),
        .pop      (m_tvalid && m_tready),
        .head     (head),
        .status   (fifo_stat)
    );

    assign m_tvalid = !fifo_stat.empty;
    assign m_tdata  = head.length;
    assign m_tuser  = head.kind;
    assign m_tlast  = head.last;

    `ATL_ASSERT_HOLDS(a_queue_bound, clk, rst_n, 32'(fifo_stat.level) <= atl_pkg::FIFO_DEPTH)
    `ATL_ASSERT_NEXT(a_stall_holds, clk, rst_n, in_vld_reg && !consume, $stable(char_reg))
    `ATL_ASSERT_NEXT(a_token_shows, clk, rst_n, consume && lex_out.count != 2'd0, m_tvalid)

endmodule
